>>> src/qte_pkg.sv
// Shared constants, payload types and helper functions for the quaternion
// to Euler angle converter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package qte_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;
  localparam int NSTG          = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

  localparam int Q_W     = 16;
  localparam int PROD_W  = 32;
  localparam int TERM_W  = 34;
  localparam int S_W     = 30;
  localparam int SQ_W    = 58;
  localparam int SQ_N    = 29;
  localparam int C_W     = 29;
  localparam int XY_W    = 36;
  localparam int Z_W     = 28;
  localparam int IDX_W   = 5;
  localparam int ANG_W   = Z_W - 11;
  localparam int ROLL_W  = 16;
  localparam int PITCH_W = 15;

  localparam logic signed [TERM_W-1:0] ONE_Q28     = 34'sd268435456;
  localparam logic signed [TERM_W-1:0] NEG_ONE_Q28 = -34'sd268435456;
  localparam logic signed [Z_W-1:0]    HALF_PI_Q24 = 28'sd26353589;
  localparam logic signed [Z_W-1:0]    ROUND_Q24   = 28'sd1024;
  localparam logic signed [ANG_W-1:0]  PI_Q13      = 17'sd25736;
  localparam logic signed [ANG_W-1:0]  HALF_PI_Q13 = 17'sd12868;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   zero;
  } cordic_t;

  typedef struct packed {
    logic signed [TERM_W-1:0] sr;
    logic signed [TERM_W-1:0] cr;
    logic signed [TERM_W-1:0] sy;
    logic signed [TERM_W-1:0] cy;
    logic signed [S_W-1:0]    s;
    logic                     clamp;
  } side_t;

  function automatic logic signed [Z_W-1:0] atan_q24(input logic [IDX_W-1:0] i);
    case (i)
      5'd0:    return 28'sd13176795;
      5'd1:    return 28'sd7778716;
      5'd2:    return 28'sd4110060;
      5'd3:    return 28'sd2086331;
      5'd4:    return 28'sd1047214;
      5'd5:    return 28'sd524117;
      5'd6:    return 28'sd262123;
      5'd7:    return 28'sd131069;
      5'd8:    return 28'sd65536;
      5'd9:    return 28'sd32768;
      5'd10:   return 28'sd16384;
      5'd11:   return 28'sd8192;
      5'd12:   return 28'sd4096;
      5'd13:   return 28'sd2048;
      5'd14:   return 28'sd1024;
      5'd15:   return 28'sd512;
      5'd16:   return 28'sd256;
      5'd17:   return 28'sd128;
      5'd18:   return 28'sd64;
      5'd19:   return 28'sd32;
      5'd20:   return 28'sd16;
      5'd21:   return 28'sd8;
      5'd22:   return 28'sd4;
      5'd23:   return 28'sd2;
      default: return '0;
    endcase
  endfunction

  // Fold the left half plane onto the right by a quarter turn.
  function automatic cordic_t cordic_pre(input logic signed [XY_W-1:0] y,
                                         input logic signed [XY_W-1:0] x);
    cordic_t r;
    r.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      if (y >= 0) begin
        r.x = y;
        r.y = -x;
        r.z = HALF_PI_Q24;
      end else begin
        r.x = -y;
        r.y = x;
        r.z = -HALF_PI_Q24;
      end
    end else begin
      r.x = x;
      r.y = y;
      r.z = '0;
    end
    return r;
  endfunction

  function automatic logic signed [ANG_W-1:0] round_q13(input logic signed [Z_W-1:0] z);
    logic signed [Z_W-1:0] t;
    t = z + ROUND_Q24;
    return t[Z_W-1:11];
  endfunction

endpackage
`default_nettype wire

>>> src/qte_quat_if.sv
// Quaternion input channel: valid/ready handshake and four Q1.14 components.
// Depends on qte_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface qte_quat_if;
  logic                            valid;
  logic                            ready;
  logic signed [qte_pkg::Q_W-1:0]  quat_w;
  logic signed [qte_pkg::Q_W-1:0]  quat_x;
  logic signed [qte_pkg::Q_W-1:0]  quat_y;
  logic signed [qte_pkg::Q_W-1:0]  quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface
`default_nettype wire

>>> src/qte_euler_if.sv
// Euler angle output channel: valid/ready handshake, roll and yaw in Q2.13,
// pitch in Q1.13 and the pitch clamp flag. Depends on qte_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface qte_euler_if;
  logic                                valid;
  logic                                ready;
  logic signed [qte_pkg::ROLL_W-1:0]   roll_angle;
  logic signed [qte_pkg::PITCH_W-1:0]  pitch_angle;
  logic signed [qte_pkg::ROLL_W-1:0]   yaw_angle;
  logic                                pitch_clamped;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                  input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                  output ready);
endinterface
`default_nettype wire

>>> src/qte_front.sv
// Front end: quaternion products, angle terms, pitch sine clamp and the
// radicand 1 - s^2 over four register stages. Depends on qte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qte_front (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic signed [qte_pkg::Q_W-1:0]  w,
  input  wire logic signed [qte_pkg::Q_W-1:0]  x,
  input  wire logic signed [qte_pkg::Q_W-1:0]  y,
  input  wire logic signed [qte_pkg::Q_W-1:0]  z,
  output logic        [qte_pkg::SQ_W-1:0]      n,
  output qte_pkg::side_t                       side
);
  import qte_pkg::*;

  logic signed [PROD_W-1:0]  pwx, pyz, pwy, pzx, pwz, pxy, pxx, pyy, pzz;
  logic signed [TERM_W-1:0]  s_raw;
  side_t                     sb, sc;
  side_t                     sb_next;
  logic signed [2*S_W-1:0]   sqp;
  logic        [SQ_W-2:0]    sq;

  always_ff @(posedge clk) begin
    if (en) begin
      pwx <= PROD_W'(w) * PROD_W'(x);
      pyz <= PROD_W'(y) * PROD_W'(z);
      pwy <= PROD_W'(w) * PROD_W'(y);
      pzx <= PROD_W'(z) * PROD_W'(x);
      pwz <= PROD_W'(w) * PROD_W'(z);
      pxy <= PROD_W'(x) * PROD_W'(y);
      pxx <= PROD_W'(x) * PROD_W'(x);
      pyy <= PROD_W'(y) * PROD_W'(y);
      pzz <= PROD_W'(z) * PROD_W'(z);
    end
  end

  always_comb begin
    sb_next.sr = (TERM_W'(pwx) + TERM_W'(pyz)) <<< 1;
    sb_next.cr = ONE_Q28 - ((TERM_W'(pxx) + TERM_W'(pyy)) <<< 1);
    sb_next.sy = (TERM_W'(pwz) + TERM_W'(pxy)) <<< 1;
    sb_next.cy = ONE_Q28 - ((TERM_W'(pyy) + TERM_W'(pzz)) <<< 1);
    s_raw      = (TERM_W'(pwy) - TERM_W'(pzx)) <<< 1;
    if (s_raw > ONE_Q28) begin
      sb_next.s     = S_W'(ONE_Q28);
      sb_next.clamp = 1'b1;
    end else if (s_raw < NEG_ONE_Q28) begin
      sb_next.s     = S_W'(NEG_ONE_Q28);
      sb_next.clamp = 1'b1;
    end else begin
      sb_next.s     = S_W'(s_raw);
      sb_next.clamp = 1'b0;
    end
  end

  assign sqp = (2*S_W)'(sb.s) * (2*S_W)'(sb.s);

  always_ff @(posedge clk) begin
    if (en) begin
      sb   <= sb_next;
      sq   <= sqp[SQ_W-2:0];
      sc   <= sb;
      n    <= (SQ_W'(1) << 56) - SQ_W'(sq);
      side <= sc;
    end
  end
endmodule
`default_nettype wire

>>> src/qte_sqrt_cell.sv
// One step of the digit-by-digit integer square root: trial subtract of
// res + 4^k. Depends on qte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qte_sqrt_cell (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [qte_pkg::IDX_W-1:0]   k,
  input  wire logic [qte_pkg::SQ_W-1:0]    n_in,
  input  wire logic [qte_pkg::SQ_W-1:0]    r_in,
  output logic      [qte_pkg::SQ_W-1:0]    n_out,
  output logic      [qte_pkg::SQ_W-1:0]    r_out
);
  import qte_pkg::*;

  logic [SQ_W-1:0] bitv;
  logic [SQ_W-1:0] trial;

  assign bitv  = SQ_W'(1) << {k, 1'b0};
  assign trial = r_in + bitv;

  always_ff @(posedge clk) begin
    if (en) begin
      if (n_in >= trial) begin
        n_out <= n_in - trial;
        r_out <= (r_in >> 1) + bitv;
      end else begin
        n_out <= n_in;
        r_out <= r_in >> 1;
      end
    end
  end
endmodule
`default_nettype wire

>>> src/qte_cordic_cell.sv
// One vectoring CORDIC iteration: shift-add rotation toward the x axis and
// angle accumulate. Depends on qte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qte_cordic_cell (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [qte_pkg::IDX_W-1:0]  stage,
  input  wire qte_pkg::cordic_t           din,
  output qte_pkg::cordic_t                dout
);
  import qte_pkg::*;

  logic signed [XY_W-1:0] xs, ys;
  cordic_t                dout_next;

  assign xs = din.x >>> stage;
  assign ys = din.y >>> stage;

  always_comb begin
    dout_next.zero = din.zero;
    if (din.y >= 0) begin
      dout_next.x = din.x + ys;
      dout_next.y = din.y - xs;
      dout_next.z = din.z + atan_q24(stage);
    end else begin
      dout_next.x = din.x - ys;
      dout_next.y = din.y + xs;
      dout_next.z = din.z - atan_q24(stage);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end
endmodule
`default_nettype wire

>>> src/quaternion_to_euler_angles.sv
// Top level of the quaternion to Euler angle converter: front end, square
// root chain, three CORDIC rows and the output register.
// Depends on qte_pkg, qte_quat_if, qte_euler_if, qte_front, qte_sqrt_cell, qte_cordic_cell.
//
// Usage:
//   quat_in carries one quaternion (w, x, y, z, signed Q1.14) per transfer.
//   euler_out carries roll, yaw (signed Q2.13 radians), pitch (signed Q1.13)
//   and the pitch clamp flag, one result per input transfer, in order.
//   Pipeline: four front-end stages, 29 square-root cells, one quarter-turn
//   stage, one cell per CORDIC iteration and the output register.
//   Throughput: one transfer per cycle unless the output stalls; every stage
//   is a register that moves in lockstep with its neighbor.
//   Stall: when a result sits in the output register and euler_out.ready is
//   low, the whole chain holds and quat_in.ready drops; items already
//   inside stay put. Bubbles keep flowing while the output register is empty.
//   Reset: rst clears all valid bits; no result is pending afterwards.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler_angles (
  input  wire logic   clk,
  input  wire logic   rst,
  qte_quat_if.sink    quat_in,
  qte_euler_if.source euler_out
);
  import qte_pkg::*;

  localparam int LAT   = 4 + SQ_N + 2 + NSTG;
  localparam int PRE_S = 4 + SQ_N;

  logic              en;
  logic [LAT-1:0]    v;
  logic [SQ_W-1:0]   n_front;
  side_t             side_front;
  side_t             side_q [SQ_N];
  logic [SQ_W-1:0]   sq_n [SQ_N];
  logic [SQ_W-1:0]   sq_r [SQ_N];
  cordic_t           pre_q [3];
  cordic_t           row [3][NSTG];
  logic [NSTG:0]     clamp_d;
  logic signed [ANG_W-1:0] ang [3];

  assign en            = !v[LAT-1] || euler_out.ready;
  assign quat_in.ready = en;
  assign euler_out.valid = v[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[LAT-2:0], quat_in.valid};
    end
  end

  qte_front u_front (
    .clk  (clk),
    .en   (en),
    .w    (quat_in.quat_w),
    .x    (quat_in.quat_x),
    .y    (quat_in.quat_y),
    .z    (quat_in.quat_z),
    .n    (n_front),
    .side (side_front)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side_front;
      for (int j = 1; j < SQ_N; j++) begin
        side_q[j] <= side_q[j-1];
      end
    end
  end

  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    if (j == 0) begin : g_first
      qte_sqrt_cell u_cell (
        .clk   (clk),
        .en    (en),
        .k     (IDX_W'(SQ_N - 1 - j)),
        .n_in  (n_front),
        .r_in  ('0),
        .n_out (sq_n[j]),
        .r_out (sq_r[j])
      );
    end else begin : g_rest
      qte_sqrt_cell u_cell (
        .clk   (clk),
        .en    (en),
        .k     (IDX_W'(SQ_N - 1 - j)),
        .n_in  (sq_n[j-1]),
        .r_in  (sq_r[j-1]),
        .n_out (sq_n[j]),
        .r_out (sq_r[j])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_q[0] <= cordic_pre(XY_W'(side_q[SQ_N-1].sr), XY_W'(side_q[SQ_N-1].cr));
      pre_q[1] <= cordic_pre(XY_W'(side_q[SQ_N-1].s),
                             $signed(XY_W'(sq_r[SQ_N-1][C_W-1:0])));
      pre_q[2] <= cordic_pre(XY_W'(side_q[SQ_N-1].sy), XY_W'(side_q[SQ_N-1].cy));
      clamp_d  <= {clamp_d[NSTG-1:0], side_q[SQ_N-1].clamp};
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_row
    for (genvar i = 0; i < NSTG; i++) begin : g_cell
      if (i == 0) begin : g_first
        qte_cordic_cell u_cell (
          .clk   (clk),
          .en    (en),
          .stage (IDX_W'(i)),
          .din   (pre_q[ch]),
          .dout  (row[ch][i])
        );
      end else begin : g_rest
        qte_cordic_cell u_cell (
          .clk   (clk),
          .en    (en),
          .stage (IDX_W'(i)),
          .din   (row[ch][i-1]),
          .dout  (row[ch][i])
        );
      end
    end
    assign ang[ch] = row[ch][NSTG-1].zero ? '0 : round_q13(row[ch][NSTG-1].z);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ang[0] > PI_Q13) begin
        euler_out.roll_angle <= ROLL_W'(PI_Q13);
      end else if (ang[0] < -PI_Q13) begin
        euler_out.roll_angle <= ROLL_W'(-PI_Q13);
      end else begin
        euler_out.roll_angle <= ROLL_W'(ang[0]);
      end
      if (ang[1] > HALF_PI_Q13) begin
        euler_out.pitch_angle <= PITCH_W'(HALF_PI_Q13);
      end else if (ang[1] < -HALF_PI_Q13) begin
        euler_out.pitch_angle <= PITCH_W'(-HALF_PI_Q13);
      end else begin
        euler_out.pitch_angle <= PITCH_W'(ang[1]);
      end
      if (ang[2] > PI_Q13) begin
        euler_out.yaw_angle <= ROLL_W'(PI_Q13);
      end else if (ang[2] < -PI_Q13) begin
        euler_out.yaw_angle <= ROLL_W'(-PI_Q13);
      end else begin
        euler_out.yaw_angle <= ROLL_W'(ang[2]);
      end
      euler_out.pitch_clamped <= clamp_d[NSTG];
    end
  end

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    quat_in.valid && quat_in.ready |=> v[0])
    else $error("accepted transfer did not enter the chain");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !rst && !en |=> $stable(v))
    else $error("valid bits moved while the chain was stalled");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    euler_out.valid |-> (euler_out.roll_angle <= 16'sd25736) &&
                        (euler_out.roll_angle >= -16'sd25736))
    else $error("roll outside plus or minus pi");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    euler_out.valid |-> (euler_out.pitch_angle <= 15'sd12868) &&
                        (euler_out.pitch_angle >= -15'sd12868))
    else $error("pitch outside plus or minus half pi");

  // PRE_S marks where the chain turns from square root to CORDIC.
  a_pre_valid: assert property (@(posedge clk) disable iff (rst)
    !rst && en && v[PRE_S-1] |=> v[PRE_S])
    else $error("item lost at the quarter-turn stage");
endmodule
`default_nettype wire

>>> test/tb_quaternion_to_euler_angles.sv
// Testbench for quaternion_to_euler_angles: drives quaternions over quat_in and checks
// roll, pitch, yaw and the clamp flag against a bit-exact CORDIC predictor.
// Depends on qte_pkg, qte_quat_if, qte_euler_if and the block itself.
`timescale 1ns / 1ps

class euler_scoreboard;
  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               clamp;
  } euler_t;

  euler_t pending[$];
  int     mismatches;

  static function longint asr(longint v, int k);
    return v >>> k;
  endfunction

  static function longint isqrt(longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  static function longint atan2_q24(longint y, longint x);
    longint z, t, xs, ys;
    longint tbl[24];
    tbl = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
            65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
            256, 128, 64, 32, 16, 8, 4, 2};
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 26353589;
      end else begin
        x = -y; y = t; z = -26353589;
      end
    end
    for (int i = 0; i < qte_pkg::CORDIC_STAGES && i < 24; i++) begin
      xs = asr(x, i);
      ys = asr(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += tbl[i];
      end else begin
        x = x - ys; y = y + xs; z -= tbl[i];
      end
    end
    return z;
  endfunction

  static function longint to_q13(longint a, longint lim);
    longint r;
    r = asr(a + 1024, 11);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function void note_quat(logic signed [15:0] qw, logic signed [15:0] qx,
                          logic signed [15:0] qy, logic signed [15:0] qz);
    longint w, x, y, z, s, c, one;
    euler_t e;
    w = qw; x = qx; y = qy; z = qz;
    one = 64'sd1 << 28;
    e.roll = 16'(to_q13(atan2_q24(2 * (w * x + y * z), one - 2 * (x * x + y * y)), 25736));
    s = 2 * (w * y - z * x);
    e.clamp = 0;
    if (s > one) begin
      s = one; e.clamp = 1;
    end else if (s < -one) begin
      s = -one; e.clamp = 1;
    end
    c = isqrt((64'd1 << 56) - longint'(s * s));
    e.pitch = 15'(to_q13(atan2_q24(s, c), 12868));
    e.yaw = 16'(to_q13(atan2_q24(2 * (w * z + x * y), one - 2 * (y * y + z * z)), 25736));
    pending.push_back(e);
  endfunction

  function void check_euler(logic signed [15:0] r, logic signed [14:0] p,
                            logic signed [15:0] y, logic cl);
    euler_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result r=%0d p=%0d y=%0d", r, p, y);
      return;
    end
    e = pending.pop_front();
    if (e.roll !== r || e.pitch !== p || e.yaw !== y || e.clamp !== cl) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch exp r=%0d p=%0d y=%0d c=%0b got r=%0d p=%0d y=%0d c=%0b",
                 e.roll, e.pitch, e.yaw, e.clamp, r, p, y, cl);
    end
  endfunction
endclass

module tb_quaternion_to_euler_angles;
  logic clk = 0;
  logic rst = 1;
  int   src_idle = 0;
  int   snk_stall = 0;
  int   idle_cycles = 0;
  bit   timed_out = 0;

  qte_quat_if  quat_in ();
  qte_euler_if euler_out ();
  euler_scoreboard sb = new();

  quaternion_to_euler_angles u_dut (.clk(clk), .rst(rst), .quat_in(quat_in),
                                    .euler_out(euler_out));

  always #6 clk = ~clk;

  initial begin
    quat_in.valid = 0;
    quat_in.quat_w = 0;
    quat_in.quat_x = 0;
    quat_in.quat_y = 0;
    quat_in.quat_z = 0;
    euler_out.ready = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (quat_in.valid && quat_in.ready)
        sb.note_quat(quat_in.quat_w, quat_in.quat_x, quat_in.quat_y, quat_in.quat_z);
      if (euler_out.valid && euler_out.ready)
        sb.check_euler(euler_out.roll_angle, euler_out.pitch_angle, euler_out.yaw_angle,
                       euler_out.pitch_clamped);
      if ((quat_in.valid && quat_in.ready) || (euler_out.valid && euler_out.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles > 5000 && !timed_out) begin
        timed_out = 1;
        $display("tb_quaternion_to_euler_angles failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    euler_out.ready <= rst ? 1'b0 : ($urandom_range(99) >= snk_stall);
  end

  task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while ($urandom_range(99) < src_idle) begin
      quat_in.valid <= 0;
      @(negedge clk);
    end
    quat_in.valid  <= 1;
    quat_in.quat_w <= w;
    quat_in.quat_x <= x;
    quat_in.quat_y <= y;
    quat_in.quat_z <= z;
    @(posedge clk);
    while (!quat_in.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    quat_in.valid <= 0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_comp(int mode);
    case (mode)
      0: return 16'($urandom());
      1: return 16'($signed($urandom_range(32768)) - 16384);
      2: return 16'($signed($urandom_range(23170)) - 11585);
      default: return 16'($signed($urandom_range(64)) - 32);
    endcase
  endfunction

  initial begin
    int mode;
    logic [15:0] e[6];
    e = '{16'h8000, 16'h7FFF, 16'h0000, 16'h4000, 16'hC000, 16'hFFFF};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);
    send_quat(0, 0, 0, 0);
    send_quat(16'h4000, 0, 0, 0);
    send_quat(16'hC000, 0, 0, 0);
    send_quat(0, 16'h4000, 0, 0);
    send_quat(0, 0, 16'h4000, 0);
    send_quat(0, 0, 0, 16'h4000);
    send_quat(16'h2D41, 0, 16'h2D41, 0);
    send_quat(16'h2D41, 0, 16'hD2BF, 0);
    send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_quat(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    for (int i = 0; i < 12; i++)
      send_quat(e[$urandom_range(5)], e[$urandom_range(5)], e[$urandom_range(5)],
                e[$urandom_range(5)]);
    wait_drained();
    for (int ph = 0; ph < 4; ph++) begin
      src_idle  = (ph == 1 || ph == 3) ? ((ph == 3) ? 22 : 53) : 0;
      snk_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 22 : 53) : 0;
      for (int i = 0; i < 445; i++) begin
        mode = $urandom_range(3);
        send_quat(pick_comp(mode), pick_comp(mode), pick_comp(mode), pick_comp(mode));
      end
      wait_drained();
    end
    src_idle = 0;
    snk_stall = 0;
    repeat (80) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("tb_quaternion_to_euler_angles passed");
    else
      $display("tb_quaternion_to_euler_angles failed");
    $finish;
  end
endmodule

>>> quaternion_to_euler_angles.f
src/qte_pkg.sv
src/qte_quat_if.sv
src/qte_euler_if.sv
src/qte_front.sv
src/qte_sqrt_cell.sv
src/qte_cordic_cell.sv
src/quaternion_to_euler_angles.sv
test/tb_quaternion_to_euler_angles.sv
